@@ rtl/core/rlws_pkg.sv @@
// Package for the raster line wave shift block.
// Holds widths, configuration indexes, control types and sine arithmetic helpers.
// No dependencies; every other file of the block but rlws_ram uses it.
package rlws_pkg;

    localparam int PIX_W      = 32;
    localparam int PHASE_W    = 16;
    localparam int AMP_W      = 6;
    localparam int SHIFT_W    = 7;
    localparam int MAG_W      = 16;
    localparam int COL_W      = 12;
    localparam int MAX_SHIFT  = 63;
    localparam int LINE_MAX   = 4096;
    localparam int WIN_DEPTH  = 128;
    localparam int WIN_AW     = 7;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 34;
    localparam int OPB_W      = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'b1;

    localparam logic [2:0] STEP_SQUARE = 3'd0;
    localparam logic [2:0] STEP_SCALE  = 3'd5;
    localparam logic [2:0] STEP_ROUND  = 3'd6;

    localparam logic [MAG_W-1:0] MAG_MAX   = 16'd32768;
    localparam logic [13:0]      QUARTER_M = 14'h3FFF;

    typedef enum logic [0:0] {
        ST_RUN,
        ST_FLUSH
    } line_state_t;

    typedef struct packed {
        logic               start;
        logic [PHASE_W-1:0] phase;
    } sine_req_t;

    typedef struct packed {
        logic               busy;
        logic               valid;
        logic [PHASE_W-1:0] phase;
        logic [MAG_W-1:0]   mag;
        logic               neg;
    } sine_rsp_t;

    // Taylor coefficients of the quarter-wave sine in Q2.30, index 0 is the linear term.
    function automatic logic signed [ACC_W-1:0] sine_coef(input logic [2:0] idx);
        logic signed [ACC_W-1:0] c;
        begin
            case (idx)
                3'd0:    c = 34'sd1686629713;
                3'd1:    c = -34'sd693598667;
                3'd2:    c = 34'sd85569306;
                3'd3:    c = -34'sd5026995;
                3'd4:    c = 34'sd172272;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

    // Signed times unsigned, scaled down by 2^30 with truncation toward zero.
    function automatic logic signed [ACC_W-1:0] mul_q30(input logic signed [ACC_W-1:0] a,
                                                        input logic [OPB_W-1:0] b);
        logic [ACC_W-1:0]         ua;
        logic [ACC_W+OPB_W-2:0]   m;
        logic [ACC_W-1:0]         q;
        begin
            ua = a[ACC_W-1] ? (~a + 1'b1) : a;
            m  = ua[ACC_W-2:0] * b;
            q  = m[ACC_W+OPB_W-2:30];
            return a[ACC_W-1] ? $signed(~q + 1'b1) : $signed(q);
        end
    endfunction

endpackage

@@ rtl/core/rlws_in_if.sv @@
// Input channel of the raster line wave shift block: one pixel column per item.
// Depends on rlws_pkg for field widths.
interface rlws_in_if;
    logic                          valid;
    logic                          ready;
    logic [rlws_pkg::PIX_W-1:0]    src_pixel;
    logic [rlws_pkg::PIX_W-1:0]    dst_pixel;
    logic                          frame_start;
    logic [rlws_pkg::PHASE_W-1:0]  start_phase;
    logic                          line_end;

    modport source (
        output valid, src_pixel, dst_pixel, frame_start, start_phase, line_end,
        input  ready
    );

    modport sink (
        input  valid, src_pixel, dst_pixel, frame_start, start_phase, line_end,
        output ready
    );
endinterface

@@ rtl/core/rlws_out_if.sv @@
// Output channel of the raster line wave shift block: one shifted pixel per item.
// Depends on rlws_pkg for field widths.
interface rlws_out_if;
    logic                       valid;
    logic                       ready;
    logic [rlws_pkg::PIX_W-1:0] out_pixel;
    logic                       last;

    modport source (
        output valid, out_pixel, last,
        input  ready
    );

    modport sink (
        input  valid, out_pixel, last,
        output ready
    );
endinterface

@@ rtl/core/rlws_ram.sv @@
// Generic simple dual-read RAM: one write port, two read ports, registered read data.
// A read of the entry written in the same cycle returns the old contents.
module rlws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ rtl/core/rlws_sine.sv @@
// Iterative sine unit: evaluates the quarter-wave polynomial with one shared multiplier.
// Keeps the last result with its phase. Depends on rlws_pkg.
module rlws_sine (
    input  logic                clk,
    input  logic                rst_n,
    input  rlws_pkg::sine_req_t req,
    output rlws_pkg::sine_rsp_t rsp
);

    logic                                 busy_reg, busy_next;
    logic [2:0]                           step_reg, step_next;
    logic [rlws_pkg::OPB_W-1:0]           t_reg, t_next;
    logic [rlws_pkg::OPB_W-1:0]           u_reg, u_next;
    logic signed [rlws_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [rlws_pkg::PHASE_W-1:0]         work_phase_reg, work_phase_next;
    logic                                 valid_reg, valid_next;
    logic [rlws_pkg::PHASE_W-1:0]         phase_reg, phase_next;
    logic [rlws_pkg::MAG_W-1:0]           mag_reg, mag_next;
    logic                                 neg_reg, neg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
            phase_reg <= '0;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg          <= t_next;
        u_reg          <= u_next;
        acc_reg        <= acc_next;
        work_phase_reg <= work_phase_next;
    end

    always_comb
    begin
        logic [14:0]                        q;
        logic signed [rlws_pkg::ACC_W-1:0]  op_a;
        logic [rlws_pkg::OPB_W-1:0]         op_b;
        logic signed [rlws_pkg::ACC_W-1:0]  prod;
        logic [rlws_pkg::ACC_W-1:0]         pos;
        logic [rlws_pkg::ACC_W:0]           rnd;
        logic [19:0]                        scaled;

        busy_next       = busy_reg;
        step_next       = step_reg;
        t_next          = t_reg;
        u_next          = u_reg;
        acc_next        = acc_reg;
        work_phase_next = work_phase_reg;
        valid_next      = valid_reg;
        phase_next      = phase_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;

        q = req.phase[14] ? (15'd16384 - {1'b0, req.phase[13:0]})
                          : {1'b0, req.phase[13:0] & rlws_pkg::QUARTER_M};

        op_a = (step_reg == rlws_pkg::STEP_SQUARE) ? $signed({3'b000, t_reg}) : acc_reg;
        op_b = ((step_reg == rlws_pkg::STEP_SQUARE) || (step_reg == rlws_pkg::STEP_SCALE))
               ? t_reg : u_reg;
        prod = rlws_pkg::mul_q30(op_a, op_b);

        pos    = acc_reg[rlws_pkg::ACC_W-1] ? '0 : acc_reg;
        rnd    = {1'b0, pos} + (rlws_pkg::ACC_W+1)'(16384);
        scaled = rnd[34:15];

        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next       = 1'b1;
                step_next       = rlws_pkg::STEP_SQUARE;
                t_next          = {q, 16'h0000};
                work_phase_next = req.phase;
            end
        end
        else
        begin
            step_next = step_reg + 3'd1;
            if (step_reg == rlws_pkg::STEP_SQUARE)
            begin
                u_next   = prod[rlws_pkg::OPB_W-1:0];
                acc_next = rlws_pkg::sine_coef(3'd4);
            end
            else if (step_reg == rlws_pkg::STEP_SCALE)
            begin
                acc_next = prod;
            end
            else if (step_reg == rlws_pkg::STEP_ROUND)
            begin
                busy_next  = 1'b0;
                valid_next = 1'b1;
                phase_next = work_phase_reg;
                neg_next   = work_phase_reg[15];
                mag_next   = (scaled > 20'(rlws_pkg::MAG_MAX)) ? rlws_pkg::MAG_MAX
                                                               : scaled[15:0];
            end
            else
            begin
                acc_next = rlws_pkg::sine_coef(3'd4 - step_reg) + prod;
            end
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.valid = valid_reg;
    assign rsp.phase = phase_reg;
    assign rsp.mag   = mag_reg;
    assign rsp.neg   = neg_reg;

endmodule

@@ rtl/core/rlws_core.sv @@
// Line control of the raster line wave shift block: column window memory, read issue,
// line-end flush and output queue. Depends on rlws_pkg, rlws_ram and the channel interfaces.
module rlws_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rlws_pkg::AMP_W-1:0]      amplitude,
    input  logic [rlws_pkg::PHASE_W-1:0]    phase_step,
    rlws_in_if.sink                         stream,
    rlws_out_if.source                      result,
    output rlws_pkg::sine_req_t             sine_req,
    input  rlws_pkg::sine_rsp_t             sine_rsp
);

    localparam int CNT_W = rlws_pkg::FIFO_AW + 1;

    rlws_pkg::line_state_t                state_reg, state_next;
    logic [rlws_pkg::COL_W-1:0]           col_reg, col_next;
    logic [rlws_pkg::PHASE_W-1:0]         phase_reg, phase_next;
    logic [rlws_pkg::AMP_W-1:0]           lag_reg, lag_next;
    logic signed [rlws_pkg::SHIFT_W-1:0]  shift_reg, shift_next;
    logic [rlws_pkg::COL_W-1:0]           flush_x_reg, flush_x_next;
    logic [rlws_pkg::COL_W-1:0]           flush_c_reg, flush_c_next;

    logic                                 rd_valid_reg;
    logic                                 rd_src_reg, rd_last_reg;
    logic                                 fwd_a_reg, fwd_b_reg;
    logic [rlws_pkg::PIX_W-1:0]           fwd_src_reg, fwd_dst_reg;

    logic [rlws_pkg::PIX_W-1:0]           fifo_pix [rlws_pkg::FIFO_DEPTH];
    logic                                 fifo_last [rlws_pkg::FIFO_DEPTH];
    logic [rlws_pkg::FIFO_AW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]                     fifo_cnt_reg;

    logic                                 col0, hit, issue_ok, accept, end_eff, emit_now;
    logic [rlws_pkg::COL_W-1:0]           c;
    logic [rlws_pkg::PHASE_W-1:0]         phase_eff;
    logic [rlws_pkg::AMP_W-1:0]           lag_new, lag_use;
    logic signed [rlws_pkg::SHIFT_W-1:0]  shift_new, shift_use;
    logic [rlws_pkg::COL_W-1:0]           x_run;
    logic                                 iss_valid, iss_last;
    logic [rlws_pkg::COL_W-1:0]           iss_x, iss_c;
    logic signed [rlws_pkg::COL_W+1:0]    j;
    logic                                 in_range;
    logic [2*rlws_pkg::PIX_W-1:0]         ram_a, ram_b;
    logic [rlws_pkg::PIX_W-1:0]           rd_pixel;
    logic                                 push, pop;

    always_comb
    begin
        logic [21:0]                  prod;
        logic [rlws_pkg::SHIFT_W-1:0] d;

        col0      = stream.frame_start || (col_reg == '0);
        c         = stream.frame_start ? '0 : col_reg;
        phase_eff = stream.frame_start ? stream.start_phase : phase_reg;
        lag_new   = (amplitude > rlws_pkg::AMP_W'(rlws_pkg::MAX_SHIFT))
                    ? rlws_pkg::AMP_W'(rlws_pkg::MAX_SHIFT) : amplitude;
        hit       = sine_rsp.valid && (sine_rsp.phase == phase_eff);
        prod      = 22'(sine_rsp.mag) * 22'(lag_new);
        d         = prod[21:15];
        shift_new = sine_rsp.neg ? -$signed(d) : $signed(d);
        lag_use   = col0 ? lag_new : lag_reg;
        shift_use = col0 ? shift_new : shift_reg;

        issue_ok = (fifo_cnt_reg + CNT_W'(rd_valid_reg)) < CNT_W'(rlws_pkg::FIFO_DEPTH);
        stream.ready = (state_reg == rlws_pkg::ST_RUN) && issue_ok
                       && (!col0 || (lag_new == '0) || hit);
        accept   = stream.valid && stream.ready;
        end_eff  = stream.line_end || (c == rlws_pkg::COL_W'(rlws_pkg::LINE_MAX - 1));
        emit_now = c >= rlws_pkg::COL_W'(lag_use);
        x_run    = c - rlws_pkg::COL_W'(lag_use);

        sine_req.phase = (stream.valid && col0 && (state_reg == rlws_pkg::ST_RUN))
                         ? phase_eff : phase_reg;
        sine_req.start = !sine_rsp.busy
                         && !(sine_rsp.valid && (sine_rsp.phase == sine_req.phase));

        state_next   = state_reg;
        col_next     = col_reg;
        phase_next   = phase_reg;
        lag_next     = lag_reg;
        shift_next   = shift_reg;
        flush_x_next = flush_x_reg;
        flush_c_next = flush_c_reg;
        iss_valid    = 1'b0;
        iss_last     = 1'b0;
        iss_x        = x_run;
        iss_c        = c;

        case (state_reg)
            rlws_pkg::ST_RUN:
            begin
                iss_valid = accept && emit_now;
                iss_last  = end_eff && (lag_use == '0);
                if (accept)
                begin
                    lag_next   = lag_use;
                    shift_next = shift_use;
                    if (end_eff)
                    begin
                        col_next   = '0;
                        phase_next = phase_eff + phase_step;
                        if (lag_use != '0)
                        begin
                            state_next   = rlws_pkg::ST_FLUSH;
                            flush_x_next = emit_now ? (x_run + 1'b1) : '0;
                            flush_c_next = c;
                        end
                    end
                    else
                    begin
                        col_next   = c + 1'b1;
                        phase_next = phase_eff;
                    end
                end
            end
            rlws_pkg::ST_FLUSH:
            begin
                iss_valid = issue_ok;
                iss_x     = flush_x_reg;
                iss_c     = flush_c_reg;
                iss_last  = flush_x_reg == flush_c_reg;
                if (issue_ok)
                begin
                    flush_x_next = flush_x_reg + 1'b1;
                    if (iss_last)
                    begin
                        state_next = rlws_pkg::ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = rlws_pkg::ST_RUN;
            end
        endcase

        j = $signed({2'b00, iss_x}) - $signed({{(rlws_pkg::COL_W + 2 - rlws_pkg::SHIFT_W)
                                                 {shift_use[rlws_pkg::SHIFT_W-1]}}, shift_use});
        if (state_reg == rlws_pkg::ST_FLUSH)
        begin
            j = $signed({2'b00, iss_x})
                - $signed({{(rlws_pkg::COL_W + 2 - rlws_pkg::SHIFT_W)
                            {shift_reg[rlws_pkg::SHIFT_W-1]}}, shift_reg});
        end
        in_range = !j[rlws_pkg::COL_W+1] && (j[rlws_pkg::COL_W:0] <= {1'b0, iss_c});
    end

    rlws_ram #(
        .WIDTH (2 * rlws_pkg::PIX_W),
        .DEPTH (rlws_pkg::WIN_DEPTH)
    ) u_window (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (c[rlws_pkg::WIN_AW-1:0]),
        .wr_data   ({stream.src_pixel, stream.dst_pixel}),
        .rd_addr_a (iss_x[rlws_pkg::WIN_AW-1:0]),
        .rd_addr_b (j[rlws_pkg::WIN_AW-1:0]),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rlws_pkg::ST_RUN;
            col_reg      <= '0;
            phase_reg    <= '0;
            lag_reg      <= '0;
            shift_reg    <= '0;
            flush_x_reg  <= '0;
            flush_c_reg  <= '0;
            rd_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            phase_reg    <= phase_next;
            lag_reg      <= lag_next;
            shift_reg    <= shift_next;
            flush_x_reg  <= flush_x_next;
            flush_c_reg  <= flush_c_next;
            rd_valid_reg <= iss_valid;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_src_reg  <= in_range;
        rd_last_reg <= iss_last;
        fwd_a_reg   <= accept && (c[rlws_pkg::WIN_AW-1:0] == iss_x[rlws_pkg::WIN_AW-1:0]);
        fwd_b_reg   <= accept && (c[rlws_pkg::WIN_AW-1:0] == j[rlws_pkg::WIN_AW-1:0]);
        fwd_src_reg <= stream.src_pixel;
        fwd_dst_reg <= stream.dst_pixel;
        if (push)
        begin
            fifo_pix[wr_ptr_reg]  <= rd_pixel;
            fifo_last[wr_ptr_reg] <= rd_last_reg;
        end
    end

    always_comb
    begin
        if (rd_src_reg)
        begin
            rd_pixel = fwd_b_reg ? fwd_src_reg : ram_b[2*rlws_pkg::PIX_W-1:rlws_pkg::PIX_W];
        end
        else
        begin
            rd_pixel = fwd_a_reg ? fwd_dst_reg : ram_a[rlws_pkg::PIX_W-1:0];
        end
    end

    assign push             = rd_valid_reg;
    assign pop              = result.valid && result.ready;
    assign result.valid     = fifo_cnt_reg != '0;
    assign result.out_pixel = fifo_pix[rd_ptr_reg];
    assign result.last      = fifo_last[rd_ptr_reg];

`ifndef ASSERT_OFF
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (fifo_cnt_reg < CNT_W'(rlws_pkg::FIFO_DEPTH)))
        else $error("Output queue written while full.");

    a_flush_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlws_pkg::ST_FLUSH) |-> !stream.ready)
        else $error("Input item taken during a line flush.");

    a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlws_pkg::ST_FLUSH) |-> (flush_x_reg <= flush_c_reg))
        else $error("Flush column ran past the line end.");

    a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_eff && (lag_use != '0)) |=> (state_reg == rlws_pkg::ST_FLUSH))
        else $error("Line end with a lag did not start a flush.");
`endif

endmodule

@@ rtl/core/raster_line_wave_shift.sv @@
// Raster line wave shift: each line is shifted by a sine-driven offset, columns stream through.
// The result for column c-A is read from the window RAM when column c is taken, then queued for output.
// Throughput: one item per cycle in a line with queue room, bounded by the one read pair of the window RAM.
// A line's first column waits for the sine result of its phase unless the lag is zero, longer if the sine is busy.
// A line end stalls input while up to A remaining columns of the line flush to the output queue.
// Reset (rst_n, asynchronous, active low) clears control state only; the window RAM is not cleared.
module raster_line_wave_shift (
    input  logic                              clk,
    input  logic                              rst_n,
    rlws_in_if.sink                           stream,
    rlws_out_if.source                        result,
    input  logic                              cfg_wr_en,
    input  logic [rlws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rlws_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [rlws_pkg::AMP_W-1:0]   amplitude_reg;
    logic [rlws_pkg::PHASE_W-1:0] phase_step_reg;
    rlws_pkg::sine_req_t          sine_req;
    rlws_pkg::sine_rsp_t          sine_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg  <= '0;
            phase_step_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rlws_pkg::CFG_AMPLITUDE:
                begin
                    amplitude_reg <= cfg_data[rlws_pkg::AMP_W-1:0];
                end
                rlws_pkg::CFG_PHASE_STEP:
                begin
                    phase_step_reg <= cfg_data[rlws_pkg::PHASE_W-1:0];
                end
                default:
                begin
                    amplitude_reg <= amplitude_reg;
                end
            endcase
        end
    end

    rlws_sine u_sine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sine_req),
        .rsp   (sine_rsp)
    );

    rlws_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .amplitude  (amplitude_reg),
        .phase_step (phase_step_reg),
        .stream     (stream),
        .result     (result),
        .sine_req   (sine_req),
        .sine_rsp   (sine_rsp)
    );

endmodule

@@ dv/rlws_scroll_checker.sv @@
`timescale 1ns / 1ps
// Checker for the raster line wave shift block: predicts every shifted output column
// from the accepted input columns and register writes, and compares in order.
// Depends on rlws_pkg and the rlws_in_if and rlws_out_if channel interfaces.
module rlws_scroll_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    rlws_in_if                              stream,
    rlws_out_if                             result,
    input  logic                            cfg_wr_en,
    input  logic [rlws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rlws_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding
);

    typedef struct packed {
        logic [rlws_pkg::PIX_W-1:0] pixel;
        logic                       last;
    } column_t;

    column_t                        pending_columns[$];
    logic [2*rlws_pkg::PIX_W-1:0]   window [rlws_pkg::WIN_DEPTH];
    int                             col_count;
    logic [rlws_pkg::PHASE_W-1:0]   line_phase;
    int                             line_offset;
    int                             line_lag;
    int                             amp_reg;
    logic [rlws_pkg::PHASE_W-1:0]   step_reg;
    int                             failures = 0;

    function automatic longint taylor_term(input int k);
        case (k)
            0:       return 1686629713;
            1:       return -693598667;
            2:       return 85569306;
            3:       return -5026995;
            default: return 172272;
        endcase
    endfunction

    // Product scaled down by 2^30, truncated toward zero.
    function automatic longint q30_product(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        logic            neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        m   = (ma * mb) >> 30;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic int quarter_wave(input int q);
        longint t;
        longint u;
        longint acc;
        int     k;
        t   = longint'(q) << 16;
        u   = q30_product(t, t);
        acc = taylor_term(4);
        for (k = 3; k >= 0; k--)
        begin
            acc = taylor_term(k) + q30_product(acc, u);
        end
        acc = q30_product(acc, t);
        if (acc < 0)
        begin
            acc = 0;
        end
        acc = (acc + 16384) >> 15;
        if (acc > 32768)
        begin
            acc = 32768;
        end
        return int'(acc);
    endfunction

    function automatic int wave_offset(input logic [rlws_pkg::PHASE_W-1:0] phase,
                                       input int lag);
        int r;
        int s;
        int d;
        r = int'(phase[13:0]);
        s = phase[14] ? quarter_wave(16384 - r) : quarter_wave(r);
        d = (s * lag) >>> 15;
        return phase[15] ? -d : d;
    endfunction

    function automatic logic [rlws_pkg::PIX_W-1:0] column_value(input int x, input int c);
        int j;
        j = x - line_offset;
        if (j < 0 || j > c)
        begin
            return window[x % rlws_pkg::WIN_DEPTH][rlws_pkg::PIX_W-1:0];
        end
        return window[j % rlws_pkg::WIN_DEPTH][2*rlws_pkg::PIX_W-1:rlws_pkg::PIX_W];
    endfunction

    task automatic predict_column(input logic [rlws_pkg::PIX_W-1:0] src,
                                  input logic [rlws_pkg::PIX_W-1:0] dst,
                                  input logic frame,
                                  input logic [rlws_pkg::PHASE_W-1:0] start,
                                  input logic line_end);
        int      c;
        int      x;
        int      first;
        logic    close;
        column_t e;
        if (frame)
        begin
            col_count  = 0;
            line_phase = start;
        end
        c = col_count;
        if (c == 0)
        begin
            line_lag    = (amp_reg > rlws_pkg::MAX_SHIFT) ? rlws_pkg::MAX_SHIFT : amp_reg;
            line_offset = wave_offset(line_phase, line_lag);
        end
        window[c % rlws_pkg::WIN_DEPTH] = {src, dst};
        close = line_end || (c >= rlws_pkg::LINE_MAX - 1);
        if (c >= line_lag)
        begin
            e.pixel = column_value(c - line_lag, c);
            e.last  = close && (line_lag == 0);
            pending_columns.push_back(e);
        end
        if (close)
        begin
            first = (c >= line_lag) ? c - line_lag + 1 : 0;
            for (x = first; x <= c; x++)
            begin
                e.pixel = column_value(x, c);
                e.last  = (x == c);
                pending_columns.push_back(e);
            end
            col_count  = 0;
            line_phase = line_phase + step_reg;
        end
        else
        begin
            col_count = (c + 1) % rlws_pkg::LINE_MAX;
        end
    endtask

    task automatic note_failure(input string what, input logic [rlws_pkg::PIX_W-1:0] want,
                                input logic [rlws_pkg::PIX_W-1:0] got);
        failures++;
        if (failures <= 10)
        begin
            $display("%0t: %s: expected %h, got %h", $time, what, want, got);
        end
    endtask

    task automatic check_result(input logic [rlws_pkg::PIX_W-1:0] pixel, input logic last);
        column_t want;
        if (pending_columns.size() == 0)
        begin
            note_failure("output item with nothing expected", '0, pixel);
        end
        else
        begin
            want = pending_columns.pop_front();
            if (want.pixel !== pixel)
            begin
                note_failure("out_pixel mismatch", want.pixel, pixel);
            end
            if (want.last !== last)
            begin
                note_failure("last mismatch", rlws_pkg::PIX_W'(want.last),
                             rlws_pkg::PIX_W'(last));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < rlws_pkg::WIN_DEPTH; i++)
            begin
                window[i] = '0;
            end
            col_count   = 0;
            line_phase  = '0;
            line_offset = 0;
            line_lag    = 0;
            amp_reg     = 0;
            step_reg    = '0;
            pending_columns.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    rlws_pkg::CFG_AMPLITUDE:  amp_reg = int'(cfg_data[rlws_pkg::AMP_W-1:0]);
                    rlws_pkg::CFG_PHASE_STEP: step_reg = cfg_data[rlws_pkg::PHASE_W-1:0];
                    default:                  ;
                endcase
            end
            if (stream.valid && stream.ready)
            begin
                predict_column(stream.src_pixel, stream.dst_pixel, stream.frame_start,
                               stream.start_phase, stream.line_end);
            end
            if (result.valid && result.ready)
            begin
                check_result(result.out_pixel, result.last);
            end
            outstanding <= pending_columns.size();
            mismatches  <= failures;
        end
    end

endmodule

@@ dv/tb_raster_line_wave_shift.sv @@
`timescale 1ns / 1ps
// Testbench top for the raster line wave shift block: drives lines of pixel columns
// and register writes with random gaps and stalls, and reports the checker's verdict.
// Depends on rlws_pkg, the channel interfaces, the block and rlws_scroll_checker.
module tb_raster_line_wave_shift;

    localparam int IDLE_PCT      = 17;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 70;
    localparam int HOLD_CYCLES   = 400;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [rlws_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rlws_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              mismatches;
    int                              outstanding;
    int                              idle_pct;
    int                              hold_request;
    int                              columns_sent;

    rlws_in_if  stream_if();
    rlws_out_if result_if();

    raster_line_wave_shift i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rlws_scroll_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_if),
        .result      (result_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [rlws_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_column(input logic [rlws_pkg::PIX_W-1:0] src,
                               input logic [rlws_pkg::PIX_W-1:0] dst,
                               input logic frame,
                               input logic [rlws_pkg::PHASE_W-1:0] phase,
                               input logic line_end);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.src_pixel   <= src;
        stream_if.dst_pixel   <= dst;
        stream_if.frame_start <= frame;
        stream_if.start_phase <= phase;
        stream_if.line_end    <= line_end;
        do
            @(posedge clk);
        while (stream_if.ready !== 1'b1);
        columns_sent++;
    endtask

    // A line sent without its end is left unfinished for a following frame start.
    task automatic send_line(input int len, input logic new_frame,
                             input logic [rlws_pkg::PHASE_W-1:0] phase, input logic closed);
        int k;
        for (k = 0; k < len; k++)
        begin
            send_column(pick_pixel(), pick_pixel(), new_frame && k == 0,
                        (new_frame && k == 0) ? phase : rlws_pkg::PHASE_W'($urandom),
                        closed && k == len - 1);
        end
    endtask

    task automatic write_register(input logic [rlws_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rlws_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        stream_if.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left       = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("tb_raster_line_wave_shift: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int                           phase_idx;
        int                           lines;
        int                           k;
        int                           len;
        int                           amp;
        logic [rlws_pkg::PHASE_W-1:0] step;
        logic                         broken;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = rlws_pkg::CFG_AMPLITUDE;
        cfg_data              = '0;
        stream_if.valid       = 1'b0;
        stream_if.src_pixel   = '0;
        stream_if.dst_pixel   = '0;
        stream_if.frame_start = 1'b0;
        stream_if.start_phase = '0;
        stream_if.line_end    = 1'b0;
        idle_pct              = IDLE_PCT;
        hold_request          = 0;
        columns_sent          = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset amplitude is zero, so the first line passes straight through.
        send_line(4, 1'b1, 16'h1234, 1'b1);
        drain();
        write_register(rlws_pkg::CFG_AMPLITUDE, rlws_pkg::CFG_DATA_W'(63));
        write_register(rlws_pkg::CFG_PHASE_STEP, 16'h4000);
        // Short line at the positive peak, then lines at zero and negative peak phases.
        send_line(8, 1'b1, 16'h4000, 1'b1);
        send_line(3, 1'b0, '0, 1'b1);
        send_line(2, 1'b0, '0, 1'b1);
        send_line(6, 1'b0, '0, 1'b0);
        send_line(66, 1'b1, 16'hFFFF, 1'b1);
        send_line(1, 1'b0, '0, 1'b1);
        drain();

        columns_sent = 0;
        phase_idx    = 0;
        while (columns_sent < RANDOM_ITEMS || phase_idx < 4)
        begin
            idle_pct = (phase_idx == 2 || phase_idx == 3) ? 0 : IDLE_PCT;
            if (phase_idx == 2)
            begin
                hold_request = HOLD_CYCLES;
            end
            case ($urandom_range(5))
                0:       amp = 0;
                1:       amp = rlws_pkg::MAX_SHIFT;
                2, 3:    amp = $urandom_range(12, 1);
                default: amp = $urandom_range(rlws_pkg::MAX_SHIFT);
            endcase
            if (phase_idx == 2)
            begin
                amp = 4;
            end
            case ($urandom_range(3))
                0:       step = '0;
                1:       step = '1;
                default: step = rlws_pkg::PHASE_W'($urandom);
            endcase
            write_register(rlws_pkg::CFG_AMPLITUDE, rlws_pkg::CFG_DATA_W'(amp));
            write_register(rlws_pkg::CFG_PHASE_STEP, step);
            lines = $urandom_range(3, 1);
            for (k = 0; k < lines; k++)
            begin
                case ($urandom_range(9))
                    0:       len = amp + 1;
                    1:       len = (amp == 0) ? 1 : amp;
                    2:       len = (amp > 1) ? amp - 1 : 1;
                    default: len = $urandom_range(24, 1);
                endcase
                if (phase_idx == 2 && k == 0)
                begin
                    len = 24;
                end
                broken = ($urandom_range(9) == 0);
                if (broken)
                begin
                    send_line($urandom_range(8, 1), 1'b0, '0, 1'b0);
                end
                send_line(len, broken || (k == 0 && $urandom_range(1) == 1),
                          rlws_pkg::PHASE_W'($urandom), 1'b1);
            end
            drain();
            phase_idx++;
        end

        if (mismatches == 0)
        begin
            $display("tb_raster_line_wave_shift: PASS");
        end
        else
        begin
            $display("tb_raster_line_wave_shift: FAIL");
        end
        $finish;
    end

endmodule

@@ raster_line_wave_shift.f @@
rtl/core/rlws_pkg.sv
rtl/core/rlws_in_if.sv
rtl/core/rlws_out_if.sv
rtl/core/rlws_ram.sv
rtl/core/rlws_sine.sv
rtl/core/rlws_core.sv
rtl/core/raster_line_wave_shift.sv
dv/rlws_scroll_checker.sv
dv/tb_raster_line_wave_shift.sv
